/* src/lds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

	localparam int NUM_VERTICES = 3;
	localparam int NORMAL_WIDTH = 16;
	localparam int WEIGHT_W     = 16;
	localparam int LIGHT_W      = 16;
	localparam int LEVEL_W      = 16;
	localparam int SHADE_W      = 17;
	localparam int SLOT_W       = 2;
	localparam int CFG_IDX_W    = 3;

	// interpolated normal, dot product and squared lengths
	localparam int NSUM_W = NORMAL_WIDTH + WEIGHT_W + 3;
	localparam int NI_W   = NSUM_W - (WEIGHT_W - 1);
	localparam int DOT_W  = NI_W + LIGHT_W + 2;
	localparam int NN_W   = 2 * NI_W + 2;
	localparam int LL_W   = 2 * LIGHT_W + 2;

	// square roots and division
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int SQN_SHIFT  = 2 * (29 - NORMAL_WIDTH);
	localparam int SQL_SHIFT  = 30;
	localparam int D_W        = 2 * ROOT_W;
	localparam int DIV_FRAC   = 60 - NORMAL_WIDTH;
	localparam int DVD_W      = DOT_W + DIV_FRAC;
	localparam int CNT_W      = $clog2(DVD_W);

	localparam logic [SHADE_W-1:0] TERM_ONE  = SHADE_W'(65536);
	localparam logic [SHADE_W-1:0] SHADE_MAX = SHADE_W'(131071);

	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE  = CFG_IDX_W'(4);

	localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = LIGHT_W'(1280);
	localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = LIGHT_W'(512);
	localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = LIGHT_W'(2560);
	localparam logic [LEVEL_W-1:0]        AMBIENT_RST = LEVEL_W'(13107);
	localparam logic [LEVEL_W-1:0]        DIFFUSE_RST = LEVEL_W'(45875);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SHADE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INTERP,
		ST_DOT,
		ST_CHECK,
		ST_SQN,
		ST_SQL_INIT,
		ST_SQL,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_SHADE,
		ST_OUT
	} lds_state_t;

	typedef struct packed {
		logic load_normal;
		logic capture;
		logic interp;
		logic dot;
		logic sqn_init;
		logic sql_init;
		logic sqrt_step;
		logic mul;
		logic div_init;
		logic div_step;
		logic shade;
		logic out_load;
	} lds_cmd_t;

	typedef struct packed {
		logic zero_term;
	} lds_stat_t;

endpackage
`default_nettype wire

/* src/lds_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lds_in_if import lds_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [SLOT_W-1:0]              vertex_slot;
	logic signed [NORMAL_WIDTH-1:0] normal_x;
	logic signed [NORMAL_WIDTH-1:0] normal_y;
	logic signed [NORMAL_WIDTH-1:0] normal_z;
	logic [WEIGHT_W-1:0]            weight_a;
	logic [WEIGHT_W-1:0]            weight_b;
	logic [WEIGHT_W-1:0]            weight_c;

	modport source (output valid, cmd, vertex_slot, normal_x, normal_y, normal_z,
		weight_a, weight_b, weight_c, input ready);
	modport sink (input valid, cmd, vertex_slot, normal_x, normal_y, normal_z,
		weight_a, weight_b, weight_c, output ready);
endinterface

interface lds_out_if import lds_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SHADE_W-1:0] shade;

	modport source (output valid, shade, input ready);
	modport sink (input valid, shade, output ready);
endinterface

interface lds_cfg_if import lds_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEVEL_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/lds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lds_datapath import lds_pkg::*; (
	input  wire                           clk,
	input  wire                           arst_n,
	input  lds_cmd_t                      cmd,
	output lds_stat_t                     stat,
	input  wire                           cfg_we,
	input  wire [CFG_IDX_W-1:0]           cfg_index,
	input  wire [LEVEL_W-1:0]             cfg_data,
	input  wire [SLOT_W-1:0]              vertex_slot,
	input  wire signed [NORMAL_WIDTH-1:0] normal_x,
	input  wire signed [NORMAL_WIDTH-1:0] normal_y,
	input  wire signed [NORMAL_WIDTH-1:0] normal_z,
	input  wire [WEIGHT_W-1:0]            weight_a,
	input  wire [WEIGHT_W-1:0]            weight_b,
	input  wire [WEIGHT_W-1:0]            weight_c,
	output logic [SHADE_W-1:0]            shade
);

	logic signed [LIGHT_W-1:0] lx_q, ly_q, lz_q;
	logic [LEVEL_W-1:0]        amb_q, gain_q;

	logic signed [NORMAL_WIDTH-1:0] nrm_q [NUM_VERTICES][3];
	logic [WEIGHT_W-1:0]            wa_q, wb_q, wc_q;
	logic signed [NI_W-1:0]         n_q [3];
	logic signed [NSUM_W-1:0]       nsum [3];

	logic signed [DOT_W-1:0] dot_q, dot_c;
	logic signed [NN_W-1:0]  nn_c;
	logic signed [LL_W-1:0]  ll_c;
	logic [NN_W-1:0]         nn_q;
	logic [LL_W-1:0]         ll_q;

	logic [RAD_W-1:0]  sq_x_q, sq_r_q, sq_b_q, sq_t;
	logic [ROOT_W-1:0] sn_q;
	logic [D_W-1:0]    d_q, rem_q;
	logic [D_W:0]      rem2, rem_sub;
	logic [DVD_W-1:0]  dvd_q;
	logic [SHADE_W-1:0] q_q, term, res_q;
	logic [SHADE_W:0]   q_next;
	logic [LEVEL_W+SHADE_W-1:0] gprod;
	logic [SHADE_W:0]   gsum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q   <= LIGHT_X_RST;
			ly_q   <= LIGHT_Y_RST;
			lz_q   <= LIGHT_Z_RST;
			amb_q  <= AMBIENT_RST;
			gain_q <= DIFFUSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIGHT_X: lx_q   <= cfg_data;
				CFG_LIGHT_Y: ly_q   <= cfg_data;
				CFG_LIGHT_Z: lz_q   <= cfg_data;
				CFG_AMBIENT: amb_q  <= cfg_data;
				CFG_DIFFUSE: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// vertex normal store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VERTICES; v++)
				for (int c = 0; c < 3; c++)
					nrm_q[v][c] <= '0;
		end else if (cmd.load_normal) begin
			for (int v = 0; v < NUM_VERTICES; v++) begin
				if (vertex_slot == SLOT_W'(v)) begin
					nrm_q[v][0] <= normal_x;
					nrm_q[v][1] <= normal_y;
					nrm_q[v][2] <= normal_z;
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			nsum[c] = $signed({1'b0, wa_q}) * nrm_q[0][c]
				+ $signed({1'b0, wb_q}) * nrm_q[1][c]
				+ $signed({1'b0, wc_q}) * nrm_q[2][c]
				+ NSUM_W'(1 << (WEIGHT_W - 2));
	end

	always_comb begin
		dot_c = n_q[0] * lx_q + n_q[1] * ly_q + n_q[2] * lz_q;
		nn_c  = n_q[0] * n_q[0] + n_q[1] * n_q[1] + n_q[2] * n_q[2];
		ll_c  = lx_q * lx_q + ly_q * ly_q + lz_q * lz_q;
	end

	assign stat.zero_term = (nn_q == '0) || (ll_q == '0) || dot_q[DOT_W-1] || (dot_q == '0);

	assign sq_t    = sq_r_q + sq_b_q;
	assign rem2    = {rem_q, dvd_q[DVD_W-1]};
	assign rem_sub = rem2 - {1'b0, d_q};
	assign q_next  = {q_q, ~rem_sub[D_W]};

	always_comb begin
		if (stat.zero_term)
			term = '0;
		else if (q_q > TERM_ONE)
			term = TERM_ONE;
		else
			term = q_q;
	end

	assign gprod = gain_q * term;
	assign gsum  = {2'b00, amb_q} + (SHADE_W + 1)'(gprod[LEVEL_W+SHADE_W-1:LEVEL_W]);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wa_q <= weight_a;
			wb_q <= weight_b;
			wc_q <= weight_c;
		end
		if (cmd.interp) begin
			for (int c = 0; c < 3; c++)
				n_q[c] <= nsum[c][NSUM_W-1:WEIGHT_W-1];
		end
		if (cmd.dot) begin
			dot_q <= dot_c;
			nn_q  <= nn_c;
			ll_q  <= ll_c;
		end
		if (cmd.sqn_init || cmd.sql_init) begin
			sq_x_q <= cmd.sqn_init ? (RAD_W'(nn_q) << SQN_SHIFT) : (RAD_W'(ll_q) << SQL_SHIFT);
			sq_r_q <= '0;
			sq_b_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (cmd.sqrt_step) begin
			if (sq_x_q >= sq_t) begin
				sq_x_q <= sq_x_q - sq_t;
				sq_r_q <= (sq_r_q >> 1) + sq_b_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_b_q <= sq_b_q >> 2;
		end
		if (cmd.sql_init)
			sn_q <= sq_r_q[ROOT_W-1:0];
		if (cmd.mul)
			d_q <= sn_q * sq_r_q[ROOT_W-1:0];
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= {dot_q, {DIV_FRAC{1'b0}}};
			q_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_sub[D_W] ? rem2[D_W-1:0] : rem_sub[D_W-1:0];
			dvd_q <= dvd_q << 1;
			q_q   <= (q_next > {1'b0, SHADE_MAX}) ? SHADE_MAX : q_next[SHADE_W-1:0];
		end
		if (cmd.shade)
			res_q <= (gsum > {1'b0, SHADE_MAX}) ? SHADE_MAX : gsum[SHADE_W-1:0];
		if (cmd.out_load)
			shade <= res_q;
	end

endmodule
`default_nettype wire

/* src/lds_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
module lds_controller import lds_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_cmd,
	output logic      in_ready,
	output logic      out_valid,
	input  wire       out_ready,
	input  lds_stat_t stat,
	output lds_cmd_t  cmd
);

	lds_state_t       state_q, state_next;
	logic [CNT_W-1:0] cnt_q;
	logic             accept, last, out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if (state_q == ST_DIV)
			last = (cnt_q == CNT_W'(DVD_W - 1));
		else
			last = (cnt_q == CNT_W'(SQRT_STEPS - 1));
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:     if (accept && in_cmd == CMD_SHADE) state_next = ST_INTERP;
			ST_INTERP:   state_next = ST_DOT;
			ST_DOT:      state_next = ST_CHECK;
			ST_CHECK:    state_next = stat.zero_term ? ST_SHADE : ST_SQN;
			ST_SQN:      if (last) state_next = ST_SQL_INIT;
			ST_SQL_INIT: state_next = ST_SQL;
			ST_SQL:      if (last) state_next = ST_MUL;
			ST_MUL:      state_next = ST_DIV_INIT;
			ST_DIV_INIT: state_next = ST_DIV;
			ST_DIV:      if (last) state_next = ST_SHADE;
			ST_SHADE:    state_next = ST_OUT;
			ST_OUT:      if (out_free) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.load_normal = accept && (in_cmd == CMD_LOAD);
		cmd.capture     = accept && (in_cmd == CMD_SHADE);
		case (state_q)
			ST_INTERP:   cmd.interp    = 1'b1;
			ST_DOT:      cmd.dot       = 1'b1;
			ST_CHECK:    cmd.sqn_init  = !stat.zero_term;
			ST_SQN:      cmd.sqrt_step = 1'b1;
			ST_SQL_INIT: cmd.sql_init  = 1'b1;
			ST_SQL:      cmd.sqrt_step = 1'b1;
			ST_MUL:      cmd.mul       = 1'b1;
			ST_DIV_INIT: cmd.div_init  = 1'b1;
			ST_DIV:      cmd.div_step  = 1'b1;
			ST_SHADE:    cmd.shade     = 1'b1;
			ST_OUT:      cmd.out_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_next;
			if ((cmd.sqrt_step || cmd.div_step) && !last)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* src/lambert_diffuse_shader_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Lambert shading of one fragment at a time. A load transfer (cmd 0) writes a
// vertex normal and gives no result. A shade transfer (cmd 1) interpolates
// the normal, forms the dot product and squared lengths, then runs two
// 32-step square roots on one shared root unit and an 82-step restoring
// division, one bit per cycle. When the normal or light has zero length or
// the surface faces away or is edge-on, the roots and division are skipped.
// The sequencer returns to idle as the result is loaded into the output
// register. New input is taken only when the sequencer is idle. A stalled
// output holds the sequencer in its last state until the output register is
// free. A finished result then waits in the output register while the next
// item starts. Configuration writes are always ready and should be made while
// no shade is in flight.
module lambert_diffuse_shader_top import lds_pkg::*; (
	input wire         clk,
	input wire         arst_n,
	lds_in_if.sink     in_ch,
	lds_out_if.source  out_ch,
	lds_cfg_if.sink    cfg_ch
);

	lds_cmd_t  cmd;
	lds_stat_t stat;

	assign cfg_ch.ready = 1'b1;

	lds_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lds_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_ch.valid),
		.cfg_index   (cfg_ch.index),
		.cfg_data    (cfg_ch.data),
		.vertex_slot (in_ch.vertex_slot),
		.normal_x    (in_ch.normal_x),
		.normal_y    (in_ch.normal_y),
		.normal_z    (in_ch.normal_z),
		.weight_a    (in_ch.weight_a),
		.weight_b    (in_ch.weight_b),
		.weight_c    (in_ch.weight_c),
		.shade       (out_ch.shade)
	);

endmodule
`default_nettype wire
